FILE: hw/rtl/box_average_image_downscaler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box average image downscaler
// Concurrent checks on the rising clock edge, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BOX_AVERAGE_IMAGE_DOWNSCALER_UNIT_ASSERT_SVH
`define BOX_AVERAGE_IMAGE_DOWNSCALER_UNIT_ASSERT_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define BADU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("downscaler: property violated");
// condition must never be true outside reset
`define BADU_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("downscaler: forbidden condition seen");
`else
`define BADU_ASSERT(label, clk, rst, prop)
`define BADU_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: hw/rtl/boxavg_pkg.sv
// ----------------------------------------------------------------------------
// boxavg_pkg
// Shared types and constants of the box average image downscaler.
// ----------------------------------------------------------------------------
package boxavg_pkg;

  localparam int CFG_DIM_W     = 13;
  localparam int CFG_GRID_W    = 7;
  localparam int CFG_DIM_MAX   = (1 << CFG_DIM_W) - 1;
  localparam int CFG_GRID_MAX  = (1 << CFG_GRID_W) - 1;
  localparam int PIX_W         = 8;
  localparam int CELL_POS_W    = 6;
  localparam int SUM_W         = 32;
  localparam int NUM_CHANNELS  = 3;
  localparam int DEFAULT_COLS  = 24;
  localparam int DEFAULT_ROWS  = 12;
  localparam int QUEUE_DEPTH   = 4;
  localparam int REG_ADDR_W    = 4;
  localparam int APB_DATA_W    = 32;

  localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd64;
  localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd64;
  localparam logic [CFG_GRID_W-1:0] RST_TARGET_COLS  = 7'd0;
  localparam logic [CFG_GRID_W-1:0] RST_TARGET_ROWS  = 7'd0;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TARGET_COLS  = 2'd2,
    REG_TARGET_ROWS  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0]  image_width;
    logic [CFG_DIM_W-1:0]  image_height;
    logic [CFG_GRID_W-1:0] target_cols;
    logic [CFG_GRID_W-1:0] target_rows;
  } cfg_t;

  // per-pixel classification made by the front end
  typedef struct packed {
    logic first;       // first pixel of its cell in this band
    logic emit;        // pixel completes its cell
    logic frame_last;  // cell is the last one of the grid
  } px_flags_t;

  typedef enum logic [1:0] {
    FS_LOAD,
    FS_START,
    FS_WAIT,
    FS_RUN
  } front_state_t;

endpackage

FILE: hw/rtl/boxavg_div.sv
// ----------------------------------------------------------------------------
// boxavg_div
// Restoring divider, one quotient bit per cycle; result held until taken.
// ----------------------------------------------------------------------------
module boxavg_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             abort,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic             take,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [CNT_W-1:0] steps;
  logic             running;
  logic             holding;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic             launch;

  assign launch = start && !running && !holding;
  assign trial  = {rem, quo[NUM_W-1]};
  assign diff   = trial - {1'b0, divisor};
  assign fits   = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst || abort) begin
      running <= 1'b0;
      holding <= 1'b0;
    end else if (launch) begin
      running <= 1'b1;
    end else if (running) begin
      if (steps == CNT_W'(1)) begin
        running <= 1'b0;
        holding <= 1'b1;
      end
    end else if (holding && take) begin
      holding <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
      steps   <= CNT_W'(NUM_W);
    end else if (running) begin
      quo   <= {quo[NUM_W-2:0], fits};
      rem   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      steps <= steps - CNT_W'(1);
    end
  end

  assign busy      = running;
  assign done      = holding;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: hw/rtl/boxavg_fifo.sv
// ----------------------------------------------------------------------------
// boxavg_fifo
// Small register queue between the front end and the accumulate back end.
// ----------------------------------------------------------------------------
`include "box_average_image_downscaler_unit_assert.svh"

module boxavg_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign valid = count != '0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  `BADU_NEVER(a_fifo_no_overflow, clk, rst, push && full)
  `BADU_NEVER(a_fifo_no_underflow, clk, rst, pop && !valid)

endmodule

FILE: hw/rtl/boxavg_front.sv
// ----------------------------------------------------------------------------
// boxavg_front
// Grid setup and raster position tracking; classifies each pixel.
// ----------------------------------------------------------------------------
`include "box_average_image_downscaler_unit_assert.svh"

module boxavg_front #(
  parameter int DIM_CAP  = 4096,
  parameter int GCOL_CAP = 64,
  parameter int GROW_CAP = 64,
  parameter int DIM_W    = 13,
  parameter int GC_W     = 7,
  parameter int GR_W     = 7,
  parameter int GX_W     = 6,
  parameter int GY_W     = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  boxavg_pkg::cfg_t         cfg,
  input  logic                     cfg_write,
  input  logic                     pixel_valid,
  output logic                     pixel_ready,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [GX_W-1:0]          q_grid_x,
  output logic [GY_W-1:0]          q_grid_y,
  output boxavg_pkg::px_flags_t    q_flags,
  output logic [DIM_W-1:0]         q_cell_w,
  output logic [DIM_W-1:0]         q_band_h
);

  import boxavg_pkg::*;

  front_state_t state, state_next;

  logic [CFG_DIM_W-1:0]  w_c, h_c;
  logic [CFG_GRID_W-1:0] cols_c, rows_c;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [GC_W-1:0]  cols_eff;
  logic [GR_W-1:0]  rows_eff;
  logic [DIM_W-1:0] wq, hq;
  logic [GC_W-1:0]  wr;
  logic [GR_W-1:0]  hr;

  logic [DIM_W-1:0] source_x, source_y;
  logic [GX_W-1:0]  grid_x;
  logic [GY_W-1:0]  grid_y;
  logic [DIM_W-1:0] x_start, x_end, y_start, y_end;
  logic [GC_W-1:0]  xr;
  logic [GR_W-1:0]  yr;

  logic             load, div_start, setup_done, accept;
  logic             w_busy, h_busy, w_done, h_done;
  logic [DIM_W-1:0] w_quo, h_quo;
  logic [GC_W-1:0]  w_rem;
  logic [GR_W-1:0]  h_rem;

  logic [DIM_W-1:0] x_next, y_next;
  logic             x_last, y_last, row_end, frame_end;
  logic [GC_W:0]    xr_sum;
  logic [GR_W:0]    yr_sum;
  logic             x_wrap, y_wrap;
  logic [GC_W-1:0]  xr_step;
  logic [GR_W-1:0]  yr_step;
  logic [DIM_W-1:0] x_end_step, y_end_step;

  // effective sizes from the register values
  always_comb begin
    if (cfg.image_width == '0) begin
      w_c = CFG_DIM_W'(1);
    end else if (cfg.image_width > CFG_DIM_W'(DIM_CAP)) begin
      w_c = CFG_DIM_W'(DIM_CAP);
    end else begin
      w_c = cfg.image_width;
    end
    if (cfg.image_height == '0) begin
      h_c = CFG_DIM_W'(1);
    end else if (cfg.image_height > CFG_DIM_W'(DIM_CAP)) begin
      h_c = CFG_DIM_W'(DIM_CAP);
    end else begin
      h_c = cfg.image_height;
    end
    cols_c = (cfg.target_cols == '0) ? CFG_GRID_W'(DEFAULT_COLS) : cfg.target_cols;
    if (cols_c > CFG_GRID_W'(GCOL_CAP)) begin
      cols_c = CFG_GRID_W'(GCOL_CAP);
    end
    if (CFG_DIM_W'(cols_c) > w_c) begin
      cols_c = CFG_GRID_W'(w_c);
    end
    rows_c = (cfg.target_rows == '0) ? CFG_GRID_W'(DEFAULT_ROWS) : cfg.target_rows;
    if (rows_c > CFG_GRID_W'(GROW_CAP)) begin
      rows_c = CFG_GRID_W'(GROW_CAP);
    end
    if (CFG_DIM_W'(rows_c) > h_c) begin
      rows_c = CFG_GRID_W'(h_c);
    end
  end

  // W/C and H/R give the per-cell step of the boundaries
  boxavg_div #(.NUM_W(DIM_W), .DEN_W(GC_W)) u_div_w (
    .clk       (clk),
    .rst       (rst),
    .abort     (cfg_write),
    .start     (div_start),
    .num       (w_eff),
    .den       (cols_eff),
    .take      (setup_done),
    .busy      (w_busy),
    .done      (w_done),
    .quotient  (w_quo),
    .remainder (w_rem)
  );

  boxavg_div #(.NUM_W(DIM_W), .DEN_W(GR_W)) u_div_h (
    .clk       (clk),
    .rst       (rst),
    .abort     (cfg_write),
    .start     (div_start),
    .num       (h_eff),
    .den       (rows_eff),
    .take      (setup_done),
    .busy      (h_busy),
    .done      (h_done),
    .quotient  (h_quo),
    .remainder (h_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      FS_LOAD:  state_next = FS_START;
      FS_START: state_next = FS_WAIT;
      FS_WAIT:  if (w_done && h_done) state_next = FS_RUN;
      FS_RUN:   state_next = FS_RUN;
    endcase
    if (cfg_write) begin
      state_next = FS_LOAD;
    end
  end

  always_comb begin
    load        = 1'b0;
    div_start   = 1'b0;
    setup_done  = 1'b0;
    pixel_ready = 1'b0;
    unique case (state)
      FS_LOAD:  load = 1'b1;
      FS_START: div_start = 1'b1;
      FS_WAIT:  setup_done = w_done && h_done;
      FS_RUN:   pixel_ready = !q_full;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign accept = pixel_valid && pixel_ready;
  assign q_push = accept;

  // classification of the current pixel
  assign x_next    = source_x + DIM_W'(1);
  assign y_next    = source_y + DIM_W'(1);
  assign x_last    = x_next == x_end;
  assign y_last    = y_next == y_end;
  assign row_end   = x_next >= w_eff;
  assign frame_end = row_end && (y_next >= h_eff);

  // next boundary: add W/C, carry the remainder
  assign xr_sum     = {1'b0, xr} + {1'b0, wr};
  assign x_wrap     = xr_sum >= {1'b0, cols_eff};
  assign xr_step    = x_wrap ? GC_W'(xr_sum - {1'b0, cols_eff}) : GC_W'(xr_sum);
  assign x_end_step = x_end + wq + DIM_W'(x_wrap);
  assign yr_sum     = {1'b0, yr} + {1'b0, hr};
  assign y_wrap     = yr_sum >= {1'b0, rows_eff};
  assign yr_step    = y_wrap ? GR_W'(yr_sum - {1'b0, rows_eff}) : GR_W'(yr_sum);
  assign y_end_step = y_end + hq + DIM_W'(y_wrap);

  assign q_grid_x           = grid_x;
  assign q_grid_y           = grid_y;
  assign q_flags.first      = (source_x == x_start) && (source_y == y_start);
  assign q_flags.emit       = x_last && y_last;
  assign q_flags.frame_last = (GC_W'(grid_x) + GC_W'(1) == cols_eff)
                           && (GR_W'(grid_y) + GR_W'(1) == rows_eff);
  assign q_cell_w           = x_end - x_start;
  assign q_band_h           = y_end - y_start;

  always_ff @(posedge clk) begin
    if (load) begin
      w_eff    <= DIM_W'(w_c);
      h_eff    <= DIM_W'(h_c);
      cols_eff <= GC_W'(cols_c);
      rows_eff <= GR_W'(rows_c);
    end
    if (setup_done) begin
      wq       <= w_quo;
      wr       <= w_rem;
      hq       <= h_quo;
      hr       <= h_rem;
      source_x <= '0;
      source_y <= '0;
      grid_x   <= '0;
      grid_y   <= '0;
      x_start  <= '0;
      x_end    <= w_quo;
      xr       <= w_rem;
      y_start  <= '0;
      y_end    <= h_quo;
      yr       <= h_rem;
    end else if (accept) begin
      if (row_end) begin
        source_x <= '0;
        grid_x   <= '0;
        x_start  <= '0;
        x_end    <= wq;
        xr       <= wr;
        if (frame_end) begin
          source_y <= '0;
          grid_y   <= '0;
          y_start  <= '0;
          y_end    <= hq;
          yr       <= hr;
        end else begin
          source_y <= y_next;
          if (y_last) begin
            grid_y  <= grid_y + GY_W'(1);
            y_start <= y_end;
            y_end   <= y_end_step;
            yr      <= yr_step;
          end
        end
      end else begin
        source_x <= x_next;
        if (x_last) begin
          grid_x  <= grid_x + GX_W'(1);
          x_start <= x_end;
          x_end   <= x_end_step;
          xr      <= xr_step;
        end
      end
    end
  end

  `BADU_ASSERT(a_pos_inside_cell, clk, rst, pixel_ready |-> (source_x < x_end) && (source_y < y_end))
  `BADU_NEVER(a_setup_div_idle_in_run, clk, rst, (state == FS_RUN) && (w_busy || h_busy))

endmodule

FILE: hw/rtl/boxavg_back.sv
// ----------------------------------------------------------------------------
// boxavg_back
// Column store accumulate, cell mean division and output register.
// ----------------------------------------------------------------------------
`include "box_average_image_downscaler_unit_assert.svh"

module boxavg_back #(
  parameter int DEPTH = 64,
  parameter int DIM_W = 13,
  parameter int GX_W  = 6,
  parameter int GY_W  = 6
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  output logic                                   q_pop,
  input  logic [boxavg_pkg::PIX_W-1:0]           q_red,
  input  logic [boxavg_pkg::PIX_W-1:0]           q_green,
  input  logic [boxavg_pkg::PIX_W-1:0]           q_blue,
  input  logic [GX_W-1:0]                        q_grid_x,
  input  logic [GY_W-1:0]                        q_grid_y,
  input  boxavg_pkg::px_flags_t                  q_flags,
  input  logic [DIM_W-1:0]                       q_cell_w,
  input  logic [DIM_W-1:0]                       q_band_h,
  output logic                                   cell_valid,
  input  logic                                   cell_ready,
  output logic [boxavg_pkg::PIX_W-1:0]           cell_red,
  output logic [boxavg_pkg::PIX_W-1:0]           cell_green,
  output logic [boxavg_pkg::PIX_W-1:0]           cell_blue,
  output logic [boxavg_pkg::CELL_POS_W-1:0]      cell_column,
  output logic [boxavg_pkg::CELL_POS_W-1:0]      cell_row,
  output logic                                   frame_done
);

  import boxavg_pkg::*;

  localparam int WORD_W  = NUM_CHANNELS * SUM_W;
  localparam int COUNT_W = 2 * DIM_W;

  logic [WORD_W-1:0] store [DEPTH];

  // accumulate stage
  logic              b_valid;
  logic [PIX_W-1:0]  b_pix [NUM_CHANNELS];
  logic [GX_W-1:0]   b_grid_x;
  logic [GY_W-1:0]   b_grid_y;
  px_flags_t         b_flags;
  logic [DIM_W-1:0]  b_cell_w;
  logic [DIM_W-1:0]  b_band_h;
  logic [WORD_W-1:0] rd_word;
  logic              b_commit;

  // last word written, for a read that raced it
  logic              last_valid;
  logic [GX_W-1:0]   last_idx;
  logic [WORD_W-1:0] last_word;

  logic [WORD_W-1:0]  base_word;
  logic [WORD_W-1:0]  new_word;
  logic [SUM_W-1:0]   new_sum [NUM_CHANNELS];
  logic [COUNT_W-1:0] cell_count;

  logic                    div_start, div_free, div_take;
  logic [NUM_CHANNELS-1:0] div_busy;
  logic [NUM_CHANNELS-1:0] div_done;
  logic [SUM_W-1:0]        div_quo [NUM_CHANNELS];

  logic [GX_W-1:0] p_col;
  logic [GY_W-1:0] p_row;
  logic            p_frame;

  assign div_free  = !(|div_busy) && !(|div_done);
  assign b_commit  = b_valid && (!b_flags.emit || div_free);
  assign q_pop     = q_valid && (!b_valid || b_commit);
  assign div_start = b_commit && b_flags.emit;
  assign div_take  = (&div_done) && (!cell_valid || cell_ready);

  always_comb begin
    if (b_flags.first) begin
      base_word = '0;
    end else if (last_valid && (last_idx == b_grid_x)) begin
      base_word = last_word;
    end else begin
      base_word = rd_word;
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      new_sum[c] = base_word[c*SUM_W +: SUM_W] + SUM_W'(b_pix[c]);
      new_word[c*SUM_W +: SUM_W] = new_sum[c];
    end
    cell_count = COUNT_W'(b_cell_w) * COUNT_W'(b_band_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      last_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid <= 1'b1;
      end else if (b_commit) begin
        b_valid <= 1'b0;
      end
      if (b_commit) begin
        last_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_word  <= store[q_grid_x];
      b_pix[0] <= q_red;
      b_pix[1] <= q_green;
      b_pix[2] <= q_blue;
      b_grid_x <= q_grid_x;
      b_grid_y <= q_grid_y;
      b_flags  <= q_flags;
      b_cell_w <= q_cell_w;
      b_band_h <= q_band_h;
    end
    if (b_commit) begin
      store[b_grid_x] <= new_word;
      last_word       <= new_word;
      last_idx        <= b_grid_x;
    end
    if (div_start) begin
      p_col   <= b_grid_x;
      p_row   <= b_grid_y;
      p_frame <= b_flags.frame_last;
    end
  end

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_div
    boxavg_div #(.NUM_W(SUM_W), .DEN_W(COUNT_W)) u_div (
      .clk       (clk),
      .rst       (rst),
      .abort     (1'b0),
      .start     (div_start),
      .num       (new_sum[c]),
      .den       (cell_count),
      .take      (div_take),
      .busy      (div_busy[c]),
      .done      (div_done[c]),
      .quotient  (div_quo[c]),
      .remainder ()
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (div_take) begin
      cell_valid <= 1'b1;
    end else if (cell_ready) begin
      cell_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      cell_red    <= div_quo[0][PIX_W-1:0];
      cell_green  <= div_quo[1][PIX_W-1:0];
      cell_blue   <= div_quo[2][PIX_W-1:0];
      cell_column <= CELL_POS_W'(p_col);
      cell_row    <= CELL_POS_W'(p_row);
      frame_done  <= p_frame;
    end
  end

  `BADU_ASSERT(a_stall_only_on_cell_end, clk, rst, (b_valid && !b_commit) |-> b_flags.emit)
  `BADU_ASSERT(a_div_launches, clk, rst, div_start |=> (&div_busy))

endmodule

FILE: hw/rtl/box_average_image_downscaler_unit.sv
// ----------------------------------------------------------------------------
// box_average_image_downscaler_unit
// Area-average downscaler of a raster RGB stream onto a grid of cells.
// ----------------------------------------------------------------------------
// Throughput: one pixel beat per cycle while the queue has room; a beat that
//   ends a cell holds the accumulate stage until the 32-step mean divider is
//   free: a new cell mean starts only after the last one has left the divider.
// Reset and every register write run a grid setup (two serial divides for the
//   boundary steps) with pixel_ready low.
// Reset is synchronous, active high; the image restarts at the top left.
// ----------------------------------------------------------------------------
module box_average_image_downscaler_unit #(
  parameter int MAX_IMAGE_DIM = 4096,
  parameter int MAX_GRID_COLS = 64,
  parameter int MAX_GRID_ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [boxavg_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [boxavg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [boxavg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready,
  // pixel stream
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  logic [boxavg_pkg::PIX_W-1:0]        pixel_red,
  input  logic [boxavg_pkg::PIX_W-1:0]        pixel_green,
  input  logic [boxavg_pkg::PIX_W-1:0]        pixel_blue,
  // cell stream
  output logic                                cell_valid,
  input  logic                                cell_ready,
  output logic [boxavg_pkg::PIX_W-1:0]        cell_red,
  output logic [boxavg_pkg::PIX_W-1:0]        cell_green,
  output logic [boxavg_pkg::PIX_W-1:0]        cell_blue,
  output logic [boxavg_pkg::CELL_POS_W-1:0]   cell_column,
  output logic [boxavg_pkg::CELL_POS_W-1:0]   cell_row,
  output logic                                frame_done
);

  import boxavg_pkg::*;

  // Image size is bounded by the 13-bit registers as well as the parameter;
  // grid size likewise by the 7-bit target registers.
  localparam int DIM_CAP  = (MAX_IMAGE_DIM < CFG_DIM_MAX) ? MAX_IMAGE_DIM : CFG_DIM_MAX;
  localparam int GCOL_CAP = (MAX_GRID_COLS < CFG_GRID_MAX) ? MAX_GRID_COLS : CFG_GRID_MAX;
  localparam int GROW_CAP = (MAX_GRID_ROWS < CFG_GRID_MAX) ? MAX_GRID_ROWS : CFG_GRID_MAX;
  localparam int DIM_W    = $clog2(DIM_CAP + 1);
  localparam int GC_W     = $clog2(GCOL_CAP + 1);
  localparam int GR_W     = $clog2(GROW_CAP + 1);
  localparam int GX_W     = $clog2(GCOL_CAP);
  localparam int GY_W     = $clog2(GROW_CAP);
  localparam int FLAG_W   = $bits(px_flags_t);
  localparam int Q_W      = NUM_CHANNELS * PIX_W + GX_W + GY_W + FLAG_W + 2 * DIM_W;

  cfg_t       cfg;
  logic       cfg_write;
  reg_index_t reg_sel;

  // queue words, front side and back side
  logic              q_push, q_full, q_pop, q_valid;
  logic [Q_W-1:0]    q_din, q_dout;
  logic [GX_W-1:0]   f_grid_x, b_grid_x;
  logic [GY_W-1:0]   f_grid_y, b_grid_y;
  px_flags_t         f_flags, b_flags;
  logic [DIM_W-1:0]  f_cell_w, b_cell_w;
  logic [DIM_W-1:0]  f_band_h, b_band_h;
  logic [PIX_W-1:0]  b_red, b_green, b_blue;

  // ---------------------------------------------------------------------
  // Register file. Every write restarts the image: the front end reruns
  // its grid setup and starts over at the top left corner. Writes are to
  // be issued only while the block is drained; the block does not enforce it.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_index_t'(paddr[REG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.target_cols  <= RST_TARGET_COLS;
      cfg.target_rows  <= RST_TARGET_ROWS;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[CFG_DIM_W-1:0];
        REG_TARGET_COLS:  cfg.target_cols  <= pwdata[CFG_GRID_W-1:0];
        REG_TARGET_ROWS:  cfg.target_rows  <= pwdata[CFG_GRID_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg.image_height);
      REG_TARGET_COLS:  prdata = APB_DATA_W'(cfg.target_cols);
      REG_TARGET_ROWS:  prdata = APB_DATA_W'(cfg.target_rows);
    endcase
  end

  // ---------------------------------------------------------------------
  // Front end: tracks the raster position and the cell boundaries. The
  // boundaries floor(k*W/C) advance by adding W/C with a remainder carry,
  // so no divide sits in the per-pixel path. Each beat is tagged with its
  // store column, whether it opens or closes its cell, and the cell size.
  // ---------------------------------------------------------------------
  boxavg_front #(
    .DIM_CAP  (DIM_CAP),
    .GCOL_CAP (GCOL_CAP),
    .GROW_CAP (GROW_CAP),
    .DIM_W    (DIM_W),
    .GC_W     (GC_W),
    .GR_W     (GR_W),
    .GX_W     (GX_W),
    .GY_W     (GY_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_write   (cfg_write),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_grid_x    (f_grid_x),
    .q_grid_y    (f_grid_y),
    .q_flags     (f_flags),
    .q_cell_w    (f_cell_w),
    .q_band_h    (f_band_h)
  );

  // ---------------------------------------------------------------------
  // Queue: lets the front keep taking pixels while the back end waits on
  // its divider or on a full output register.
  // ---------------------------------------------------------------------
  assign q_din = {pixel_red, pixel_green, pixel_blue,
                  f_grid_x, f_grid_y, f_flags, f_cell_w, f_band_h};
  assign {b_red, b_green, b_blue,
          b_grid_x, b_grid_y, b_flags, b_cell_w, b_band_h} = q_dout;

  boxavg_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  // ---------------------------------------------------------------------
  // Back end: read-add-write on the column store (the first beat of a
  // cell in a band overwrites, which stands in for clearing the store),
  // then the three channel means on serial dividers into the output
  // register.
  // ---------------------------------------------------------------------
  boxavg_back #(
    .DEPTH (GCOL_CAP),
    .DIM_W (DIM_W),
    .GX_W  (GX_W),
    .GY_W  (GY_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_red       (b_red),
    .q_green     (b_green),
    .q_blue      (b_blue),
    .q_grid_x    (b_grid_x),
    .q_grid_y    (b_grid_y),
    .q_flags     (b_flags),
    .q_cell_w    (b_cell_w),
    .q_band_h    (b_band_h),
    .cell_valid  (cell_valid),
    .cell_ready  (cell_ready),
    .cell_red    (cell_red),
    .cell_green  (cell_green),
    .cell_blue   (cell_blue),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .frame_done  (frame_done)
  );

endmodule

FILE: bench/box_average_image_downscaler_unit_tb.sv
// ----------------------------------------------------------------------------
// box_average_image_downscaler_unit_tb
// Streams raster RGB pixels into the downscaler under a range of geometry
// settings and checks every cell beat against a local area-average predictor.
// The tests run directed corner cases first, then random frames under four
// handshake idling mixes.
// ----------------------------------------------------------------------------
module box_average_image_downscaler_unit_tb;
  import boxavg_pkg::*;

  localparam int MAX_IMAGE_DIM = 4096;
  localparam int MAX_GRID_COLS = 64;
  localparam int MAX_GRID_ROWS = 64;
  localparam int CLK_PERIOD    = 8;
  // leave ample margin after the last cell beat before reconfig
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int LIMIT_CYCLES  = 1000000;

  // one finished cell as the block reports it
  typedef struct packed {
    logic [PIX_W-1:0]      red;
    logic [PIX_W-1:0]      green;
    logic [PIX_W-1:0]      blue;
    logic [CELL_POS_W-1:0] column;
    logic [CELL_POS_W-1:0] row;
    logic                  frame_last;
  } cell_beat_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [REG_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    pixel_valid = 1'b0;
  logic                    pixel_ready;
  logic [PIX_W-1:0]        pixel_red = '0;
  logic [PIX_W-1:0]        pixel_green = '0;
  logic [PIX_W-1:0]        pixel_blue = '0;
  logic                    cell_valid;
  logic                    cell_ready = 1'b0;
  logic [PIX_W-1:0]        cell_red;
  logic [PIX_W-1:0]        cell_green;
  logic [PIX_W-1:0]        cell_blue;
  logic [CELL_POS_W-1:0]   cell_column;
  logic [CELL_POS_W-1:0]   cell_row;
  logic                    frame_done;

  // predictor copy of the registers
  logic [CFG_DIM_W-1:0]    cfg_width;
  logic [CFG_DIM_W-1:0]    cfg_height;
  logic [CFG_GRID_W-1:0]   cfg_cols;
  logic [CFG_GRID_W-1:0]   cfg_rows;

  // predictor copy of the raster position and column store
  logic [SUM_W-1:0]        red_acc   [MAX_GRID_COLS];
  logic [SUM_W-1:0]        green_acc [MAX_GRID_COLS];
  logic [SUM_W-1:0]        blue_acc  [MAX_GRID_COLS];
  logic [11:0]             src_col;
  logic [11:0]             src_row;
  logic [CELL_POS_W-1:0]   grid_col;
  logic [CELL_POS_W-1:0]   grid_row;
  logic [11:0]             cell_left;
  logic [12:0]             cell_right;
  logic [11:0]             band_top;
  logic [12:0]             band_bottom;

  cell_beat_t              expected_cells[$];
  cell_beat_t              next_cell;
  int                      fail_count = 0;
  int unsigned             send_idle_pct = 0;
  int unsigned             recv_stall_pct = 0;

  box_average_image_downscaler_unit #(
    .MAX_IMAGE_DIM(MAX_IMAGE_DIM),
    .MAX_GRID_COLS(MAX_GRID_COLS),
    .MAX_GRID_ROWS(MAX_GRID_ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel_red(pixel_red),
    .pixel_green(pixel_green),
    .pixel_blue(pixel_blue),
    .cell_valid(cell_valid),
    .cell_ready(cell_ready),
    .cell_red(cell_red),
    .cell_green(cell_green),
    .cell_blue(cell_blue),
    .cell_column(cell_column),
    .cell_row(cell_row),
    .frame_done(frame_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Geometry helpers: effective sizes after saturation and clamping
  // ---------------------------------------------------------------------------
  function automatic int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_IMAGE_DIM) return MAX_IMAGE_DIM;
    return v;
  endfunction

  function automatic int unsigned clamp_grid(logic [CFG_GRID_W-1:0] t, int unsigned dflt,
                                             int unsigned maxg, int unsigned dim);
    int unsigned n;
    n = (t == 0) ? dflt : t;
    if (n > maxg) n = maxg;
    if (n > dim) n = dim;
    return n;
  endfunction

  function automatic int unsigned frame_width();
    return clamp_dim(cfg_width);
  endfunction

  function automatic int unsigned frame_height();
    return clamp_dim(cfg_height);
  endfunction

  function automatic int unsigned grid_cols();
    return clamp_grid(cfg_cols, DEFAULT_COLS, MAX_GRID_COLS, frame_width());
  endfunction

  function automatic int unsigned grid_rows();
    return clamp_grid(cfg_rows, DEFAULT_ROWS, MAX_GRID_ROWS, frame_height());
  endfunction

  // floor(k*dim/n); n is never zero after clamping, but guard anyway
  function automatic int unsigned boundary(int unsigned k, int unsigned dim, int unsigned n);
    return (n == 0) ? dim : (k * dim) / n;
  endfunction

  function automatic void clear_column_sums();
    foreach (red_acc[i]) begin
      red_acc[i]   = '0;
      green_acc[i] = '0;
      blue_acc[i]  = '0;
    end
  endfunction

  // back to the top left corner with an empty column store
  function automatic void restart_image();
    clear_column_sums();
    src_col     = '0;
    src_row     = '0;
    grid_col    = '0;
    grid_row    = '0;
    cell_left   = '0;
    band_top    = '0;
    cell_right  = boundary(1, frame_width(), grid_cols());
    band_bottom = boundary(1, frame_height(), grid_rows());
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: fold one accepted pixel in, queue a cell beat if it ends a cell
  // ---------------------------------------------------------------------------
  function automatic void predict_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                        logic [PIX_W-1:0] b);
    int unsigned w, h, ncols, nrows, area, col;
    bit          x_last, y_last;
    cell_beat_t  beat;
    w     = frame_width();
    h     = frame_height();
    ncols = grid_cols();
    nrows = grid_rows();
    col   = (grid_col >= MAX_GRID_COLS) ? MAX_GRID_COLS - 1 : grid_col;
    red_acc[col]   += r;
    green_acc[col] += g;
    blue_acc[col]  += b;
    x_last = (src_col + 1 == cell_right);
    y_last = (src_row + 1 == band_bottom);

    if (x_last && y_last) begin
      area = (cell_right - cell_left) * (band_bottom - band_top);
      if (area == 0) area = 1;
      beat.red        = red_acc[col] / area;
      beat.green      = green_acc[col] / area;
      beat.blue       = blue_acc[col] / area;
      beat.column     = grid_col;
      beat.row        = grid_row;
      beat.frame_last = (grid_col + 1 == ncols) && (grid_row + 1 == nrows);
      expected_cells.push_back(beat);
    end

    if (src_col + 1 >= w) begin
      // end of a source line
      src_col    = '0;
      grid_col   = '0;
      cell_left  = '0;
      cell_right = boundary(1, w, ncols);
      if (y_last) begin
        // last pixel of the frame wraps to a fresh image
        if (src_row + 1 >= h) begin
          restart_image();
          return;
        end
        clear_column_sums();
        grid_row++;
        band_top    = band_bottom;
        band_bottom = boundary(grid_row + 1, h, nrows);
      end
      src_row++;
      if (src_row >= h) restart_image();
    end else begin
      src_col++;
      if (x_last) begin
        grid_col++;
        cell_left  = cell_right;
        cell_right = boundary(grid_col + 1, w, ncols);
      end
    end
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus plumbing
  // ---------------------------------------------------------------------------
  // one APB transfer: setup phase, access phase until pready, then idle
  task automatic apb_transfer(bit is_write, reg_index_t idx, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= REG_ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write restarts the image in the block and in the predictor; read back after
  task automatic write_register(reg_index_t idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] mask, readback;
    mask = (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) ?
           (1 << CFG_DIM_W) - 1 : (1 << CFG_GRID_W) - 1;
    apb_transfer(1'b1, idx, value, readback);
    case (idx)
      REG_IMAGE_WIDTH:  cfg_width  = value[CFG_DIM_W-1:0];
      REG_IMAGE_HEIGHT: cfg_height = value[CFG_DIM_W-1:0];
      REG_TARGET_COLS:  cfg_cols   = value[CFG_GRID_W-1:0];
      default:          cfg_rows   = value[CFG_GRID_W-1:0];
    endcase
    restart_image();
    apb_transfer(1'b0, idx, '0, readback);
    check_field("register readback", value & mask, readback & mask);
  endtask

  // stop sending, wait for every queued cell, then let the pipe go quiet
  task automatic drain_results(int settle);
    pixel_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_geometry(logic [CFG_DIM_W-1:0] w, logic [CFG_DIM_W-1:0] h,
                              logic [CFG_GRID_W-1:0] c, logic [CFG_GRID_W-1:0] r);
    drain_results(SETTLE_CYCLES);
    write_register(REG_IMAGE_WIDTH, w);
    write_register(REG_IMAGE_HEIGHT, h);
    write_register(REG_TARGET_COLS, c);
    write_register(REG_TARGET_ROWS, r);
  endtask

  // one pixel beat; random idle gap first, valid held until accepted
  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_red   <= r;
    pixel_green <= g;
    pixel_blue  <= b;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    predict_pixel(r, g, b);
  endtask

  task automatic send_random_pixel();
    send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // zero sizes saturate to 1x1: every pixel is a whole frame
  task automatic test_single_pixel_image();
    set_geometry('0, '0, '0, '0);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'haa, 8'h55, 8'haa);
  endtask

  // all-ones registers: sizes saturate to the maxima, no cell completes
  task automatic test_largest_registers();
    set_geometry('1, '1, '1, '1);
    send_pixel(8'h55, 8'haa, 8'h55);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hff, 8'h00);
  endtask

  // targets above the image size clamp to one pixel per cell; last beat wraps
  task automatic test_grid_clamped_to_image();
    set_geometry(13'd3, 13'd2, 7'd64, 7'd64);
    repeat (7) send_random_pixel();
  endtask

  // uneven column and row boundaries, with a full drain in mid frame
  task automatic test_uneven_boundaries();
    set_geometry(13'd4, 13'd3, 7'd3, 7'd2);
    repeat (6) send_random_pixel();
    drain_results(0);
    repeat (6) send_random_pixel();
  endtask

  task automatic test_random_frames();
    int unsigned          phase, sent, frame_px, burst, pick;
    logic [CFG_DIM_W-1:0]  w, h;
    logic [CFG_GRID_W-1:0] c, r;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 83; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct = 22; recv_stall_pct = 22;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          // default grid of 24 x 12
          w = $urandom_range(24, 32);
          h = $urandom_range(12, 13);
          c = '0;
          r = '0;
        end else if (pick == 1) begin
          // wide, shallow image
          w = $urandom_range(64, 200);
          h = $urandom_range(1, 2);
          c = $urandom_range(127);
          r = $urandom_range(127);
        end else if (pick == 2) begin
          // narrow, tall image
          w = $urandom_range(1, 3);
          h = $urandom_range(20, 100);
          c = $urandom_range(127);
          r = $urandom_range(127);
        end else begin
          w = $urandom_range(0, 16);
          h = $urandom_range(0, 12);
          c = $urandom_range(1) ? $urandom_range(0, 8) : $urandom_range(127);
          r = $urandom_range(1) ? $urandom_range(0, 6) : $urandom_range(127);
        end
        set_geometry(w, h, c, r);
        frame_px = frame_width() * frame_height();
        pick = $urandom_range(9);
        if (pick < 2)
          burst = $urandom_range(1, frame_px);       // cut short by the next write
        else if (frame_px <= 64)
          burst = frame_px * $urandom_range(1, 3);   // back-to-back frames
        else
          burst = frame_px;
        for (int k = 0; k < burst; k++) begin
          send_random_pixel();
          sent++;
          if ($urandom_range(199) == 0) drain_results(0);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Cell sink: random stalls per phase, compare each beat with the oldest one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cell_ready <= rst ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && cell_valid && cell_ready) begin
      if (expected_cells.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected cell beat, expected none, got column %0d row %0d",
                 $time, cell_column, cell_row);
      end else begin
        next_cell = expected_cells.pop_front();
        check_field("cell_red", next_cell.red, cell_red);
        check_field("cell_green", next_cell.green, cell_green);
        check_field("cell_blue", next_cell.blue, cell_blue);
        check_field("cell_column", next_cell.column, cell_column);
        check_field("cell_row", next_cell.row, cell_row);
        check_field("frame_done", next_cell.frame_last, frame_done);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_width  = RST_IMAGE_WIDTH;
    cfg_height = RST_IMAGE_HEIGHT;
    cfg_cols   = RST_TARGET_COLS;
    cfg_rows   = RST_TARGET_ROWS;
    restart_image();
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_single_pixel_image();
    test_largest_registers();
    test_grid_clamped_to_image();
    test_uneven_boundaries();
    test_random_frames();

    drain_results(SETTLE_CYCLES);
    if (fail_count == 0 && expected_cells.size() == 0)
      $display("box_average_image_downscaler_unit_tb passed");
    else
      $display("box_average_image_downscaler_unit_tb failed");
    $finish;
  end

  // hang guard
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("box_average_image_downscaler_unit_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/boxavg_pkg.sv
hw/rtl/boxavg_div.sv
hw/rtl/boxavg_fifo.sv
hw/rtl/boxavg_front.sv
hw/rtl/boxavg_back.sv
hw/rtl/box_average_image_downscaler_unit.sv
bench/box_average_image_downscaler_unit_tb.sv
